[design/ipv6p_pkg.sv]
// ----------------------------------------------------------------------------
// ipv6p_pkg
// Shared types and constants for the IPv6 address text parser.
// ----------------------------------------------------------------------------
package ipv6p_pkg;

  localparam int unsigned GROUPS      = 8;
  localparam int unsigned GROUP_W     = 16;
  localparam int unsigned MAX_DIGITS  = 4;
  localparam int unsigned MAX_COLONS  = 2;

  localparam logic [3:0] GAP_NONE     = 4'd8;
  localparam logic [3:0] GROUPS_FULL  = 4'd8;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_COLON = 8'h3a;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_MANY    = 3'd1,
    ST_LONG_GROUP  = 3'd2,
    ST_SECOND_GAP  = 3'd3,
    ST_TOO_FEW     = 3'd4
  } status_t;

  typedef logic [GROUP_W-1:0] group_t;

endpackage

[design/ipv6p_if.sv]
// ----------------------------------------------------------------------------
// ipv6p_if
// Valid/ready channels: character beats in, parse result beats out.
// ----------------------------------------------------------------------------
interface ipv6p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_text;

  modport source (output valid, output character, output end_of_text, input ready);
  modport sink   (input valid, input character, input end_of_text, output ready);
endinterface

interface ipv6p_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] address_high;
  logic [63:0] address_low;
  logic        stopped_on_character;

  modport source (output valid, output status, output address_high, output address_low,
                  output stopped_on_character, input ready);
  modport sink   (input valid, input status, input address_high, input address_low,
                  input stopped_on_character, output ready);
endinterface

[design/ipv6_address_text_parser.sv]
// ----------------------------------------------------------------------------
// ipv6_address_text_parser
// Parses IPv6 address text, one character beat at a time, into 128 bits.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one character beat per cycle (character, end_of_text).
//            end_of_text or an error closes the parse; a character neither hex
//            digit nor allowed colon closes it too, taken but not parsed.
//   out_ch : one result beat per finished parse: status, address_high,
//            address_low, stopped_on_character. Beats that do not close a
//            parse give no result.
//   Result:  a result is in the output register in the cycle after the beat
//            that closes the parse. Throughput: one beat per cycle while
//            in_ch.ready is high; parse state updates when a beat is taken.
//   Stall:   the single output register holds a result until taken; a new
//            input beat is taken whenever that register is empty or is
//            being emptied in the same cycle.
//   Reset:   rst_n (synchronous, low) clears the parse state and the output
//            valid. The group store is not cleared; it is only read at
//            entries written in the current parse.
// ----------------------------------------------------------------------------
module ipv6_address_text_parser (
  input  logic        clk,
  input  logic        rst_n,
  ipv6p_in_if.sink    in_ch,
  ipv6p_out_if.source out_ch
);

  ipv6p_pkg::group_t group_store_r [ipv6p_pkg::GROUPS];
  ipv6p_pkg::group_t cur_group_r, cur_group_nxt;
  logic [3:0] group_cnt_r, group_cnt_nxt;
  logic [2:0] digit_cnt_r, digit_cnt_nxt;
  logic [1:0] colon_run_r, colon_run_nxt;
  logic [3:0] gap_pos_r, gap_pos_nxt;

  logic        out_valid_r;
  logic [2:0]  status_r, status_nxt;
  logic [63:0] addr_hi_r, addr_hi_nxt;
  logic [63:0] addr_lo_r, addr_lo_nxt;
  logic        stopped_r, stopped_nxt;

  logic       accept;
  logic       emit;
  logic       do_finish;
  logic       store_en;
  logic       is_digit;
  logic       is_colon;
  logic [3:0] digit_val;
  logic [1:0] colon_inc;

  ipv6p_pkg::group_t eff [ipv6p_pkg::GROUPS];
  ipv6p_pkg::group_t full [ipv6p_pkg::GROUPS];
  logic [3:0] n_groups;
  logic [3:0] fill;
  logic       full_ok;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // character decode
  always_comb begin
    is_digit  = 1'b0;
    digit_val = 4'd0;
    if (in_ch.character >= ipv6p_pkg::CH_0 && in_ch.character <= ipv6p_pkg::CH_9) begin
      is_digit  = 1'b1;
      digit_val = 4'(in_ch.character - ipv6p_pkg::CH_0);
    end else if (in_ch.character >= ipv6p_pkg::CH_LC_A &&
                 in_ch.character <= ipv6p_pkg::CH_LC_F) begin
      is_digit  = 1'b1;
      digit_val = 4'(in_ch.character - ipv6p_pkg::CH_LC_A) + 4'd10;
    end else if (in_ch.character >= ipv6p_pkg::CH_UC_A &&
                 in_ch.character <= ipv6p_pkg::CH_UC_F) begin
      is_digit  = 1'b1;
      digit_val = 4'(in_ch.character - ipv6p_pkg::CH_UC_A) + 4'd10;
    end
    is_colon  = (in_ch.character == ipv6p_pkg::CH_COLON) &&
                (colon_run_r < 2'(ipv6p_pkg::MAX_COLONS));
    colon_inc = colon_run_r + 2'd1;
  end

  // gap expansion at end of parse; pending digits count as the last group
  always_comb begin
    for (int i = 0; i < ipv6p_pkg::GROUPS; i++) begin
      eff[i] = group_store_r[i];
      if (digit_cnt_r != 3'd0 && group_cnt_r == 4'(i)) begin
        eff[i] = cur_group_r;
      end
    end
    n_groups = group_cnt_r +
               4'((digit_cnt_r != 3'd0 && group_cnt_r < ipv6p_pkg::GROUPS_FULL) ? 1 : 0);
    fill     = ipv6p_pkg::GROUPS_FULL - n_groups;
    full_ok  = (gap_pos_r < ipv6p_pkg::GAP_NONE) || (n_groups == ipv6p_pkg::GROUPS_FULL);
    for (int i = 0; i < ipv6p_pkg::GROUPS; i++) begin
      if (gap_pos_r == ipv6p_pkg::GAP_NONE || 4'(i) < gap_pos_r) begin
        full[i] = eff[i];
      end else if (5'(i) < 5'(gap_pos_r) + 5'(fill)) begin
        full[i] = '0;
      end else begin
        full[i] = eff[3'(4'(i) - fill)];
      end
    end
  end

  // per-beat step
  always_comb begin
    cur_group_nxt = cur_group_r;
    group_cnt_nxt = group_cnt_r;
    digit_cnt_nxt = digit_cnt_r;
    colon_run_nxt = colon_run_r;
    gap_pos_nxt   = gap_pos_r;
    emit          = 1'b0;
    do_finish     = 1'b0;
    store_en      = 1'b0;
    status_nxt    = ipv6p_pkg::ST_OK;
    stopped_nxt   = 1'b0;
    addr_hi_nxt   = '0;
    addr_lo_nxt   = '0;

    if (in_ch.end_of_text) begin
      do_finish = 1'b1;
    end else if (!is_digit && !is_colon) begin
      do_finish   = 1'b1;
      stopped_nxt = 1'b1;
    end else if (group_cnt_r >= ipv6p_pkg::GROUPS_FULL) begin
      emit       = 1'b1;
      status_nxt = ipv6p_pkg::ST_TOO_MANY;
    end else if (is_digit) begin
      if (digit_cnt_r >= 3'(ipv6p_pkg::MAX_DIGITS)) begin
        emit       = 1'b1;
        status_nxt = ipv6p_pkg::ST_LONG_GROUP;
      end else begin
        cur_group_nxt = {cur_group_r[11:0], digit_val};
        colon_run_nxt = 2'd0;
        digit_cnt_nxt = digit_cnt_r + 3'd1;
      end
    end else begin
      colon_run_nxt = colon_inc;
      if (colon_inc == 2'(ipv6p_pkg::MAX_COLONS)) begin
        if (gap_pos_r < ipv6p_pkg::GAP_NONE) begin
          emit       = 1'b1;
          status_nxt = ipv6p_pkg::ST_SECOND_GAP;
        end else begin
          gap_pos_nxt = group_cnt_r;
        end
      end
      if (!emit && digit_cnt_r != 3'd0) begin
        store_en      = 1'b1;
        group_cnt_nxt = group_cnt_r + 4'd1;
        cur_group_nxt = '0;
        digit_cnt_nxt = 3'd0;
      end
    end

    if (do_finish) begin
      emit = 1'b1;
      if (full_ok) begin
        status_nxt  = ipv6p_pkg::ST_OK;
        addr_hi_nxt = {full[0], full[1], full[2], full[3]};
        addr_lo_nxt = {full[4], full[5], full[6], full[7]};
      end else begin
        status_nxt = ipv6p_pkg::ST_TOO_FEW;
      end
    end

    if (emit) begin
      cur_group_nxt = '0;
      group_cnt_nxt = 4'd0;
      digit_cnt_nxt = 3'd0;
      colon_run_nxt = 2'd0;
      gap_pos_nxt   = ipv6p_pkg::GAP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_en) begin
      group_store_r[group_cnt_r[2:0]] <= cur_group_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_group_r <= '0;
      group_cnt_r <= 4'd0;
      digit_cnt_r <= 3'd0;
      colon_run_r <= 2'd0;
      gap_pos_r   <= ipv6p_pkg::GAP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cur_group_r <= cur_group_nxt;
        group_cnt_r <= group_cnt_nxt;
        digit_cnt_r <= digit_cnt_nxt;
        colon_run_r <= colon_run_nxt;
        gap_pos_r   <= gap_pos_nxt;
      end
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      status_r  <= status_nxt;
      addr_hi_r <= addr_hi_nxt;
      addr_lo_r <= addr_lo_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.status               = status_r;
  assign out_ch.address_high         = addr_hi_r;
  assign out_ch.address_low          = addr_lo_r;
  assign out_ch.stopped_on_character = stopped_r;

endmodule
